[rtl/stbs_pkg.sv]
// Shared types and constants for the sorted-table binary search core.
// Holds the controller state type, the command and status bundles and field codes.
// No dependencies; every other file imports this package.
`default_nettype none

package stbs_pkg;

    // Default table depth handed to the top level.
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int MODE_W  = 3;

    // Item kinds carried in the func field.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Search modes.
    localparam logic [MODE_W-1:0] MODE_EXACT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST_GE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST_GT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LAST_LE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LAST_LT  = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } stbs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;    // store the accepted entry
        logic start;    // load target and mode, reset the bounds
        logic read;     // compute the midpoint and read that entry
        logic compare;  // compare the read entry and narrow the bounds
        logic emit;     // load the output register with the result
    } stbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_empty;  // lower bound has reached the upper bound
        logic mode_ok;      // the held mode is a known search mode
        logic exact_hit;    // exact mode and the probed entry equals the target
        logic out_free;     // the output register can take a result
    } stbs_status_t;

endpackage : stbs_pkg

`default_nettype wire

[rtl/stbs_ctrl.sv]
// Controller state machine for the sorted-table binary search core.
// Sequences entry writes and the read/compare steps of each search.
// Depends on stbs_pkg for the state type and the command and status bundles.
`default_nettype none

module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         func,
    input  wire stbs_status_t sts,
    output stbs_cmd_t         cmd
);

    stbs_state_t state_reg;
    stbs_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (func == FUNC_SEARCH))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.range_empty || !sts.mode_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.exact_hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: handshake ready and datapath commands.
    always_comb
    begin
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.write = s_tvalid && (func == FUNC_WRITE);
                cmd.start = s_tvalid && (func == FUNC_SEARCH);
            end
            ST_READ:
            begin
                cmd.read = !sts.range_empty && sts.mode_ok;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
            end
            ST_DONE:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule : stbs_ctrl

`default_nettype wire

[rtl/stbs_datapath.sv]
// Datapath for the sorted-table binary search core: table memory, entry count,
// search bounds, comparator, answer tracking and the output register.
// Depends on stbs_pkg; driven by commands from stbs_ctrl.
`default_nettype none

module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wen,
    input  wire logic [COUNT_W-1:0]         cfg_wdata,
    input  wire logic [MODE_W-1:0]          mode,
    input  wire logic [INDEX_W-1:0]         entry_index,
    input  wire logic signed [VALUE_W-1:0]  data_value,
    input  wire stbs_cmd_t                  cmd,
    output stbs_status_t                    sts,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic                            found,
    output logic [INDEX_W-1:0]              position
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Table storage, undefined until written.
    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]        entry_count_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic signed [VALUE_W-1:0] target_reg;
    logic [CNT_W-1:0]          lo_reg;
    logic [CNT_W-1:0]          lo_next;
    logic [CNT_W-1:0]          hi_reg;
    logic [CNT_W-1:0]          hi_next;
    logic [CNT_W-1:0]          mid_reg;
    logic [CNT_W-1:0]          mid_calc;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic [CNT_W-1:0]          ans_reg;
    logic [CNT_W-1:0]          ans_next;
    logic                      m_valid_reg;
    logic                      m_found_reg;
    logic [INDEX_W-1:0]        m_pos_reg;

    logic [31:0]               count_wide;
    logic [31:0]               count_sat;
    logic [CNT_W-1:0]          count_eff;
    logic [31:0]               index_wide;
    logic                      write_ok;
    logic [ADDR_W+INDEX_W-1:0] wr_addr_wide;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [CNT_W+INDEX_W-1:0]  pos_wide;
    logic                      less;
    logic                      equal;
    logic                      go_left;
    logic                      record;

    // Entry count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wen)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    // Effective entry count, saturated at the table depth.
    assign count_wide = {{(32-COUNT_W){1'b0}}, entry_count_reg};
    assign count_sat  = (count_wide > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : count_wide;
    assign count_eff  = count_sat[CNT_W-1:0];

    // Write address; an index beyond the table is dropped.
    assign index_wide   = {{(32-INDEX_W){1'b0}}, entry_index};
    assign write_ok     = index_wide < 32'(TABLE_DEPTH);
    assign wr_addr_wide = {{ADDR_W{1'b0}}, entry_index};
    assign wr_addr      = wr_addr_wide[ADDR_W-1:0];

    // Midpoint of the current bounds (upper bound is exclusive).
    assign mid_calc = lo_reg + ((hi_reg - lo_reg - CNT_W'(1)) >> 1);
    assign rd_addr  = mid_calc[ADDR_W-1:0];

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write && write_ok)
        begin
            mem[wr_addr] <= data_value;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Search operands and probe index.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg   <= mode;
            target_reg <= data_value;
        end
        if (cmd.read)
        begin
            mid_reg <= mid_calc;
        end
    end

    // Comparison of the probed entry against the target.
    assign less  = rd_data_reg < target_reg;
    assign equal = rd_data_reg == target_reg;

    // Direction and answer capture for each mode.
    always_comb
    begin
        go_left = 1'b0;
        record  = 1'b0;
        case (mode_reg)
            MODE_EXACT:
            begin
                go_left = !less && !equal;
                record  = equal;
            end
            MODE_FIRST_GE:
            begin
                go_left = !less;
                record  = go_left;
            end
            MODE_FIRST_GT:
            begin
                go_left = !less && !equal;
                record  = go_left;
            end
            MODE_LAST_LE:
            begin
                go_left = !less && !equal;
                record  = !go_left;
            end
            MODE_LAST_LT:
            begin
                go_left = !less;
                record  = !go_left;
            end
            default:
            begin
                go_left = 1'b0;
                record  = 1'b0;
            end
        endcase
    end

    // Bound and answer updates.
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        hit_next = hit_reg;
        ans_next = ans_reg;
        if (cmd.start)
        begin
            lo_next  = '0;
            hi_next  = count_eff;
            hit_next = 1'b0;
            ans_next = '0;
        end
        else if (cmd.compare)
        begin
            if (go_left)
            begin
                hi_next = mid_reg;
            end
            else
            begin
                lo_next = mid_reg + CNT_W'(1);
            end
            if (record)
            begin
                hit_next = 1'b1;
                ans_next = mid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        hit_reg <= hit_next;
        ans_reg <= ans_next;
    end

    // Output register; a held result leaves once the downstream side takes it.
    assign pos_wide = {{INDEX_W{1'b0}}, ans_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_found_reg <= hit_reg;
            m_pos_reg   <= hit_reg ? pos_wide[INDEX_W-1:0] : '0;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        sts.range_empty = !(lo_reg < hi_reg);
        sts.mode_ok     = mode_reg inside {[MODE_EXACT:MODE_LAST_LT]};
        sts.exact_hit   = (mode_reg == MODE_EXACT) && equal;
        sts.out_free    = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign found    = m_found_reg;
    assign position = m_pos_reg;

endmodule : stbs_datapath

`default_nettype wire

[rtl/sorted_table_binary_search_core.sv]
// Sorted-table binary search core: a write is taken straight from the idle state; each search
// probe is a memory read (READ state), then a compare (CMP state), with at most floor(log2(n))+1
// probes, after which the DONE state loads the output register once that register is free. The
// single registered memory read port splits each probe into these two steps. Writes follow back
// to back; a search closes the input until its result is in the output register.
// Reset (rst_n, asynchronous) clears the controller, the output valid and the entry count.
`default_nettype none

module sorted_table_binary_search_core
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration: entry count.
    input  wire logic               cfg_wen,
    input  wire logic [COUNT_W-1:0] cfg_wdata,
    // Input stream.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [47:0]        s_tdata,   // entry_index[9:0], data_value[41:10], zero pad
    input  wire logic [3:0]         s_tuser,   // func[0], mode[3:1]
    // Result stream.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,   // position[9:0], zero pad
    output logic                    m_tuser    // found[0]
);

    stbs_cmd_t          cmd;
    stbs_status_t       sts;
    logic [INDEX_W-1:0] position;

    // Sequencing of writes and search probes.
    stbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, bounds, comparator and output register.
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .mode        (s_tuser[3:1]),
        .entry_index (s_tdata[9:0]),
        .data_value  (s_tdata[41:10]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .found       (m_tuser),
        .position    (position)
    );

    assign m_tdata = {6'b0, position};

endmodule : sorted_table_binary_search_core

`default_nettype wire

[bench/sorted_table_binary_search_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for sorted_table_binary_search_core: loads tables, runs searches in
// every mode and compares each result with an in-bench prediction of the binary search.
// Depends on stbs_pkg and the core; needs no files or arguments.

module sorted_table_binary_search_core_tb
    import stbs_pkg::*;
();

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    // Highest code the mode field can carry; codes above MODE_LAST_LT are unknown.
    localparam logic [MODE_W-1:0] MODE_TOP = 3'd7;
    // Cycles to let the block settle before a register write.
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic             found;
        logic [INDEX_W-1:0] position;
    } search_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic [COUNT_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;    // entry_index[9:0], data_value[41:10], zero pad
    logic [3:0]         s_tuser;    // func[0], mode[3:1]
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;    // position[9:0], zero pad
    logic               m_tuser;    // found[0]

    // Bench copy of the table and the entry count.
    logic signed [VALUE_W-1:0] entry_model [0:TABLE_DEPTH-1];
    logic [COUNT_W-1:0]        count_model;

    // Search results still awaited from the block, oldest first.
    search_result_t pending_results[$];

    int error_count;
    bit quiet;          // no idling on either side
    int hold_request;   // asks the receiver for one long hold-off, in cycles

    sorted_table_binary_search_core #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock, 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Binary search over the bench table, probing in the same order as the block.
    function automatic search_result_t predict_search(input logic [MODE_W-1:0] mode,
                                                      input logic signed [VALUE_W-1:0] target);
        search_result_t res;
        int n;
        int lo;
        int hi;
        int mid;
        int ans;
        logic signed [VALUE_W-1:0] v;
        logic go_left;
        logic hit;
        res.found = 1'b0;
        res.position = '0;
        n = (count_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_model);
        lo = 0;
        hi = n - 1;
        ans = -1;
        hit = 1'b0;
        // Unknown modes never find anything.
        if (mode > MODE_LAST_LT)
            hi = -1;
        while (!hit && lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            v = entry_model[mid];
            case (mode)
                MODE_EXACT:
                begin
                    if (v == target)
                    begin
                        hit = 1'b1;
                        ans = mid;
                    end
                    go_left = v > target;
                end
                MODE_FIRST_GE:
                begin
                    go_left = v >= target;
                    if (go_left)
                        ans = mid;
                end
                MODE_FIRST_GT:
                begin
                    go_left = v > target;
                    if (go_left)
                        ans = mid;
                end
                MODE_LAST_LE:
                begin
                    go_left = !(v <= target);
                    if (!go_left)
                        ans = mid;
                end
                MODE_LAST_LT:
                begin
                    go_left = !(v < target);
                    if (!go_left)
                        ans = mid;
                end
                default:
                    go_left = 1'b0;
            endcase
            if (go_left)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        if (ans >= 0)
        begin
            res.found = 1'b1;
            res.position = ans[INDEX_W-1:0];
        end
        return res;
    endfunction

    // A target near the first n entries, or a random or extreme value.
    function automatic logic [VALUE_W-1:0] pick_target(input int n);
        int k;
        k = $urandom_range(0, (n > 0 ? n : 1) - 1);
        case ($urandom_range(0, 5))
            0, 1:    return entry_model[k];
            2:       return entry_model[k] + 1;
            3:       return entry_model[k] - 1;
            4:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    // Mostly known modes, now and then an unknown one.
    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 9) == 0)
            return MODE_W'($urandom_range(MODE_LAST_LT + 1, MODE_TOP));
        return MODE_W'($urandom_range(MODE_EXACT, MODE_LAST_LT));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Offers one item, waits for its transfer and updates the prediction.
    task automatic send_item(input logic func, input logic [MODE_W-1:0] mode,
                             input logic [INDEX_W-1:0] index,
                             input logic [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {mode, func};
        s_tdata  <= {6'b0, value, index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (func == FUNC_WRITE)
            entry_model[index] = value;
        else
            pending_results.push_back(predict_search(mode, value));
    endtask

    task automatic search(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] target);
        send_item(FUNC_SEARCH, mode, INDEX_W'($urandom), target);
    endtask

    // Stops offering, waits for every awaited result and lets the block go idle.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [COUNT_W-1:0] value);
        drain_and_settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        count_model = value;
    endtask

    // An empty table never finds anything, whatever the mode or target.
    task automatic test_empty_table();
        write_entry_count(11'd0);
        search(MODE_EXACT, 32'd0);
        search(MODE_FIRST_GE, 32'h8000_0000);
        search(MODE_FIRST_GT, 32'h8000_0000);
        search(MODE_LAST_LE, 32'h7fff_ffff);
        search(MODE_LAST_LT, 32'h7fff_ffff);
    endtask

    // Five entries with a duplicate pair and both extremes of the value range.
    task automatic test_small_table_edges();
        send_item(FUNC_WRITE, MODE_EXACT, 10'd0, 32'h8000_0000);
        send_item(FUNC_WRITE, MODE_EXACT, 10'd1, -32'sd5);
        send_item(FUNC_WRITE, MODE_EXACT, 10'd2, 32'd7);
        send_item(FUNC_WRITE, MODE_EXACT, 10'd3, 32'd7);
        send_item(FUNC_WRITE, MODE_EXACT, 10'd4, 32'h7fff_ffff);
        // A single entry.
        write_entry_count(11'd1);
        search(MODE_EXACT, 32'h8000_0000);
        search(MODE_FIRST_GT, 32'h8000_0000);
        // Whole table: duplicates, misses and both ends.
        write_entry_count(11'd5);
        search(MODE_EXACT, 32'd7);
        search(MODE_EXACT, 32'd6);
        search(MODE_FIRST_GE, 32'h8000_0000);
        search(MODE_FIRST_GT, 32'h7fff_ffff);
        search(MODE_LAST_LE, 32'h7fff_ffff);
        search(MODE_LAST_LT, 32'h8000_0000);
        search(MODE_FIRST_GT, 32'd7);
        search(MODE_LAST_LT, 32'd7);
    endtask

    // Unknown mode codes on a table that holds a match.
    task automatic test_unknown_modes();
        search(MODE_W'(MODE_LAST_LT + 1), 32'd7);
        search(MODE_W'(MODE_TOP - 1), 32'd7);
        search(MODE_TOP, 32'd7);
    endtask

    // The receiver holds off for a long stretch so the block fills up and stalls its input.
    task automatic test_output_hold();
        hold_request = 300;
        repeat (20)
            search(pick_mode(), pick_target(5));
    endtask

    // Fills every entry in ascending order from the lowest to the highest value, then
    // searches at full depth and with a count beyond the depth.
    task automatic test_full_table();
        longint v;
        v = -64'sd2147483648;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
                v = 64'sd2147483647;
            send_item(FUNC_WRITE, MODE_EXACT, INDEX_W'(i), v[VALUE_W-1:0]);
            if ($urandom_range(0, 7) != 0)
                v += $urandom_range(1, 8000000);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
        end
        write_entry_count(11'd1024);
        repeat (30)
            search(pick_mode(), pick_target(TABLE_DEPTH));
        write_entry_count(11'd2047);
        repeat (20)
            search(pick_mode(), pick_target(TABLE_DEPTH));
    endtask

    // One random table: mostly sorted, sometimes unsorted, sometimes a count past the
    // loaded prefix, with stray entry writes among the searches.
    task automatic test_random_table();
        int n;
        int extra;
        int r;
        bit sorted;
        longint v;
        int max_step;
        r = $urandom_range(0, 9);
        n = (r == 0) ? 0 : (r <= 2) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 0;
        sorted = $urandom_range(0, 5) != 0;
        max_step = $urandom_range(0, 1) ? 3 : (1 << 26);
        v = longint'($signed($urandom));
        write_entry_count(COUNT_W'(n + extra));
        for (int i = 0; i < n; i++)
        begin
            if (sorted)
            begin
                send_item(FUNC_WRITE, MODE_EXACT, INDEX_W'(i), v[VALUE_W-1:0]);
                if ($urandom_range(0, 5) != 0)
                    v += $urandom_range(1, max_step);
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
            end
            else
                send_item(FUNC_WRITE, MODE_EXACT, INDEX_W'(i), $urandom);
        end
        repeat ($urandom_range(15, 25))
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(FUNC_WRITE, pick_mode(), INDEX_W'($urandom), $urandom);
            else
                search(pick_mode(), pick_target(n));
        end
    endtask

    // Receiver: random stall bursts, the long hold-off on request, none when quiet.
    initial
    begin : receiver
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Each result transfer is compared with the oldest awaited search.
    always @(posedge clk)
    begin : result_check
        search_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no search awaiting it",
                                int'(m_tdata[INDEX_W-1:0]), -1);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("found", int'(m_tuser), int'(want.found));
                if (m_tdata[INDEX_W-1:0] !== want.position)
                    report_mismatch("position", int'(m_tdata[INDEX_W-1:0]),
                                    int'(want.position));
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        error_count = 0;
        quiet = 1'b0;
        hold_request = 0;
        count_model = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            entry_model[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_small_table_edges();
        test_unknown_modes();
        test_output_hold();
        test_full_table();
        repeat (7)
            test_random_table();
        // Final stretch runs without idling on either side.
        quiet = 1'b1;
        test_random_table();

        drain_and_settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("%0t ns: run limit reached", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/stbs_pkg.sv
rtl/stbs_ctrl.sv
rtl/stbs_datapath.sv
rtl/sorted_table_binary_search_core.sv
bench/sorted_table_binary_search_core_tb.sv
